// ----- sv/lmfe_pkg.sv -----
// Package for the LIN master frame engine: transaction types, operation and
// result codes, and the protected-identifier and checksum functions.
// No dependencies.
package lmfe_pkg;

   localparam int MAX_RESULTS = 5;
   localparam int COUNT_W     = 3;

   localparam logic [1:0] OP_REQUEST = 2'd0;
   localparam logic [1:0] OP_COMMAND = 2'd1;
   localparam logic [1:0] OP_RX_BYTE = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   localparam logic [2:0] KIND_BREAK     = 3'd0;
   localparam logic [2:0] KIND_BYTE      = 3'd1;
   localparam logic [2:0] KIND_RESP_OK   = 3'd2;
   localparam logic [2:0] KIND_ECHO_BAD  = 3'd3;
   localparam logic [2:0] KIND_CHECK_BAD = 3'd4;
   localparam logic [2:0] KIND_TIMEOUT   = 3'd5;

   localparam logic [7:0] SYNC_BYTE       = 8'h55;
   localparam logic [7:0] TIMEOUT_RESET   = 8'd8;
   localparam logic [7:0] ELAPSED_MAX     = 8'd255;

   typedef struct packed {
      logic [1:0] op;
      logic [5:0] frame_id;
      logic [7:0] data_byte;
   } lmfe_req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] byte_value;
      logic       last;
   } lmfe_rsp_type;

   // Protected identifier: id plus the two LIN parity bits.
   function automatic logic [7:0] make_pid(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

   // Enhanced checksum: carry-wrapped sum of identifier and data, inverted.
   function automatic logic [7:0] enh_checksum(input logic [7:0] pid,
                                               input logic [7:0] data);
      logic [8:0] sum;
      logic [7:0] wrapped;
      sum     = {1'b0, pid} + {1'b0, data};
      wrapped = sum[7:0] + {7'd0, sum[8]};
      return ~wrapped;
   endfunction

endpackage

// ----- sv/lmfe_core.sv -----
// Frame logic of the LIN master engine: response wait state, timeout register
// and the result list produced for one transaction.
// Depends on lmfe_pkg.
module lmfe_core import lmfe_pkg::*; (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [7:0]                         csr_wr_data,
   input  logic                               fire,
   input  lmfe_req_type                       item,
   output lmfe_rsp_type [MAX_RESULTS-1:0]     results,
   output logic [COUNT_W-1:0]                 result_count
);

   logic       awaiting_ff, awaiting_in;
   logic [7:0] expected_pid_ff, expected_pid_in;
   logic [1:0] rx_count_ff, rx_count_in;
   logic [7:0] echo_byte_ff, echo_byte_in;
   logic [7:0] resp_data_ff, resp_data_in;
   logic [7:0] elapsed_ff, elapsed_in;
   logic [7:0] timeout_ff;

   logic [7:0] pid;
   logic [7:0] elapsed_inc;
   logic [2:0] verdict;

   always_comb begin
      pid             = make_pid(item.frame_id);
      elapsed_inc     = (elapsed_ff < ELAPSED_MAX) ? elapsed_ff + 8'd1 : elapsed_ff;
      verdict         = KIND_RESP_OK;
      results         = '0;
      result_count    = '0;
      awaiting_in     = awaiting_ff;
      expected_pid_in = expected_pid_ff;
      rx_count_in     = rx_count_ff;
      echo_byte_in    = echo_byte_ff;
      resp_data_in    = resp_data_ff;
      elapsed_in      = elapsed_ff;

      // The echo check takes priority over the checksum check.
      if (echo_byte_ff != expected_pid_ff) begin
         verdict = KIND_ECHO_BAD;
      end else if (item.data_byte != enh_checksum(expected_pid_ff, resp_data_ff)) begin
         verdict = KIND_CHECK_BAD;
      end

      unique case (item.op)
         OP_REQUEST: begin
            results[0]      = '{KIND_BREAK, 8'd0, 1'b0};
            results[1]      = '{KIND_BYTE, SYNC_BYTE, 1'b0};
            results[2]      = '{KIND_BYTE, pid, 1'b1};
            result_count    = COUNT_W'(3);
            expected_pid_in = pid;
            awaiting_in     = 1'b1;
            rx_count_in     = 2'd0;
            elapsed_in      = 8'd0;
         end
         OP_COMMAND: begin
            results[0]   = '{KIND_BREAK, 8'd0, 1'b0};
            results[1]   = '{KIND_BYTE, SYNC_BYTE, 1'b0};
            results[2]   = '{KIND_BYTE, pid, 1'b0};
            results[3]   = '{KIND_BYTE, item.data_byte, 1'b0};
            results[4]   = '{KIND_BYTE, enh_checksum(pid, item.data_byte), 1'b1};
            result_count = COUNT_W'(5);
            awaiting_in  = 1'b0;
            rx_count_in  = 2'd0;
            elapsed_in   = 8'd0;
         end
         OP_RX_BYTE: begin
            if (awaiting_ff) begin
               if (rx_count_ff == 2'd0) begin
                  echo_byte_in = item.data_byte;
                  rx_count_in  = 2'd1;
               end else if (rx_count_ff == 2'd1) begin
                  resp_data_in = item.data_byte;
                  rx_count_in  = 2'd2;
               end else begin
                  results[0]   = '{verdict, resp_data_ff, 1'b1};
                  result_count = COUNT_W'(1);
                  awaiting_in  = 1'b0;
                  rx_count_in  = 2'd0;
                  elapsed_in   = 8'd0;
               end
            end
         end
         OP_TICK: begin
            if (!awaiting_ff) begin
               elapsed_in = 8'd0;
            end else if (elapsed_inc >= timeout_ff) begin
               results[0]   = '{KIND_TIMEOUT, 8'd0, 1'b1};
               result_count = COUNT_W'(1);
               awaiting_in  = 1'b0;
               rx_count_in  = 2'd0;
               elapsed_in   = 8'd0;
            end else begin
               elapsed_in = elapsed_inc;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff     <= 1'b0;
         expected_pid_ff <= 8'd0;
         rx_count_ff     <= 2'd0;
         elapsed_ff      <= 8'd0;
         timeout_ff      <= TIMEOUT_RESET;
      end else begin
         if (fire) begin
            awaiting_ff     <= awaiting_in;
            expected_pid_ff <= expected_pid_in;
            rx_count_ff     <= rx_count_in;
            elapsed_ff      <= elapsed_in;
         end
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // Response bytes are always written before they are read.
   always_ff @(posedge clock) begin
      if (fire) begin
         echo_byte_ff <= echo_byte_in;
         resp_data_ff <= resp_data_in;
      end
   end

endmodule

// ----- sv/lin_master_frame_engine.sv -----
// LIN master frame engine. The first result of a transaction passes the input
// register, where it waits while the result register is busy, then the result register.
// Throughput: one transaction per cycle while the result register is free, limited
// by result delivery: a request gives 3 results, a command 5, a verdict or timeout 1.
// Reset (synchronous, active high) clears the wait, the queues and sets the
// timeout register to 8 ticks. Depends on lmfe_pkg and lmfe_core.
module lin_master_frame_engine import lmfe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  lmfe_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output lmfe_rsp_type rsp_data
);

   logic                           in_valid_ff;
   lmfe_req_type                   in_item_ff;
   lmfe_rsp_type [MAX_RESULTS-1:0] slots_ff, slots_in;
   logic [COUNT_W-1:0]             count_ff, count_in;

   lmfe_rsp_type [MAX_RESULTS-1:0] new_results;
   logic [COUNT_W-1:0]             new_count;
   logic                           take;
   logic                           burst_free;
   logic                           process;

   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = slots_ff[0];
   assign take       = rsp_valid && rsp_ready;
   // The result register can take a new burst once its last result leaves.
   assign burst_free = (count_ff == '0) || ((count_ff == COUNT_W'(1)) && take);
   assign process    = in_valid_ff && burst_free;
   assign req_ready  = !in_valid_ff || process;

   lmfe_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fire         (process),
      .item         (in_item_ff),
      .results      (new_results),
      .result_count (new_count)
   );

   always_comb begin
      slots_in = slots_ff;
      count_in = count_ff;
      if (process) begin
         slots_in = new_results;
         count_in = new_count;
      end else if (take) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slots_in[i] = slots_ff[i+1];
         end
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (process) begin
            in_valid_ff <= 1'b0;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      slots_ff <= slots_in;
   end

endmodule

// ----- test/lmfe_checker.sv -----
// Checker for the LIN master frame engine: watches the register port and both
// handshake channels, predicts every result and compares it field by field.
// Depends on lmfe_pkg for the transaction types and the operation and kind codes.
`timescale 1ns / 1ps

module lmfe_checker import lmfe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,
   input  logic         req_valid,
   input  logic         req_ready,
   input  lmfe_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  lmfe_rsp_type rsp_data,
   output int           error_count,
   output int           outstanding,
   output int           txn_count,
   output int           result_count,
   output int           verdict_count,
   output int           timeout_count
);

   localparam logic [7:0] TICKS_AFTER_RESET = 8'd8;

   // Predicted engine state.
   logic [7:0] timeout_ticks;
   logic       waiting;
   logic [7:0] pending_pid;
   logic [1:0] bytes_in;
   logic [7:0] echo_seen;
   logic [7:0] data_seen;
   logic [7:0] ticks_seen;

   lmfe_rsp_type pending_results[$];
   lmfe_rsp_type want;
   int           reported;

   function automatic logic [7:0] protect_id(input logic [5:0] id);
      logic [7:0] pid;
      pid[5:0] = id;
      pid[6]   = ^{id[4], id[2], id[1], id[0]};
      pid[7]   = ~^{id[5], id[4], id[3], id[1]};
      return pid;
   endfunction

   // The carry out of the eight-bit sum is folded back in before inversion.
   function automatic logic [7:0] enhanced_sum(input logic [7:0] pid,
                                               input logic [7:0] value);
      logic [8:0] total;
      total = {1'b0, pid} + {1'b0, value};
      if (total[8])
         total = total - 9'd255;
      return ~total[7:0];
   endfunction

   function automatic void push_rsp(input logic [2:0] kind, input logic [7:0] value,
                                    input logic last_flag);
      lmfe_rsp_type item;
      item.kind       = kind;
      item.byte_value = value;
      item.last       = last_flag;
      pending_results.push_back(item);
   endfunction

   function automatic void end_wait();
      waiting    = 1'b0;
      bytes_in   = 2'd0;
      ticks_seen = 8'd0;
   endfunction

   task automatic advance_engine(input lmfe_req_type item);
      logic [7:0] pid;
      logic [2:0] verdict;
      pid = protect_id(item.frame_id);
      case (item.op)
         OP_REQUEST: begin
            end_wait();
            push_rsp(KIND_BREAK, 8'd0, 1'b0);
            push_rsp(KIND_BYTE, SYNC_BYTE, 1'b0);
            push_rsp(KIND_BYTE, pid, 1'b1);
            pending_pid = pid;
            waiting     = 1'b1;
         end
         OP_COMMAND: begin
            end_wait();
            push_rsp(KIND_BREAK, 8'd0, 1'b0);
            push_rsp(KIND_BYTE, SYNC_BYTE, 1'b0);
            push_rsp(KIND_BYTE, pid, 1'b0);
            push_rsp(KIND_BYTE, item.data_byte, 1'b0);
            push_rsp(KIND_BYTE, enhanced_sum(pid, item.data_byte), 1'b1);
         end
         OP_RX_BYTE: begin
            if (waiting) begin
               if (bytes_in == 2'd0) begin
                  echo_seen = item.data_byte;
                  bytes_in  = 2'd1;
               end else if (bytes_in == 2'd1) begin
                  data_seen = item.data_byte;
                  bytes_in  = 2'd2;
               end else begin
                  // A bad echo takes precedence over a bad checksum.
                  if (echo_seen != pending_pid)
                     verdict = KIND_ECHO_BAD;
                  else if (item.data_byte != enhanced_sum(pending_pid, data_seen))
                     verdict = KIND_CHECK_BAD;
                  else
                     verdict = KIND_RESP_OK;
                  end_wait();
                  push_rsp(verdict, data_seen, 1'b1);
                  verdict_count++;
               end
            end
         end
         default: begin
            if (!waiting) begin
               ticks_seen = 8'd0;
            end else begin
               if (ticks_seen != 8'hFF)
                  ticks_seen = ticks_seen + 8'd1;
               if (ticks_seen >= timeout_ticks) begin
                  end_wait();
                  push_rsp(KIND_TIMEOUT, 8'd0, 1'b1);
                  timeout_count++;
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timeout_ticks = TICKS_AFTER_RESET;
         waiting       = 1'b0;
         pending_pid   = 8'd0;
         bytes_in      = 2'd0;
         echo_seen     = 8'd0;
         data_seen     = 8'd0;
         ticks_seen    = 8'd0;
         pending_results.delete();
         error_count   = 0;
         reported      = 0;
         txn_count     = 0;
         result_count  = 0;
         verdict_count = 0;
         timeout_count = 0;
      end else begin
         if (csr_wr_en)
            timeout_ticks = csr_wr_data;
         // Results are checked before the new transaction is predicted; the block
         // cannot answer a transaction in the cycle that accepts it.
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               error_count++;
               if (reported < 10) begin
                  reported++;
                  $display("Unexpected result %0d: kind %0d byte %02h last %0b",
                           result_count, rsp_data.kind, rsp_data.byte_value,
                           rsp_data.last);
               end
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.byte_value !== want.byte_value ||
                   rsp_data.last !== want.last) begin
                  error_count++;
                  if (reported < 10) begin
                     reported++;
                     $display("Result %0d expected %0d/%02h/%0b, got %0d/%02h/%0b",
                              result_count, want.kind, want.byte_value, want.last,
                              rsp_data.kind, rsp_data.byte_value, rsp_data.last);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            txn_count++;
            advance_engine(req_data);
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

// ----- test/testbench.sv -----
// Top of the LIN master frame engine testbench: clock, reset, register writes,
// request stimulus and response back-pressure, and the final verdict.
// Depends on lmfe_pkg, lin_master_frame_engine and lmfe_checker.
`timescale 1ns / 1ps

module testbench;
   import lmfe_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic [7:0]   csr_wr_data = 8'd0;
   logic         req_valid = 1'b0;
   logic         req_ready;
   lmfe_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   lmfe_rsp_type rsp_data;

   int error_count;
   int outstanding;
   int txn_count;
   int result_count;
   int verdict_count;
   int timeout_count;

   bit calm = 1'b0;
   bit hold_long = 1'b0;
   int sent = 0;
   int settings_used = 0;

   lin_master_frame_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   lmfe_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .error_count  (error_count),
      .outstanding  (outstanding),
      .txn_count    (txn_count),
      .result_count (result_count),
      .verdict_count(verdict_count),
      .timeout_count(timeout_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Run did not finish in time.");
      $display("FAIL");
      $finish;
   end

   // Result side: random stalls, a long hold on request, always ready once calm.
   initial begin
      @(negedge clock);
      forever begin
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance with
   // valid possibly still high, so the caller either offers again or lowers it.
   task automatic offer(input logic [1:0] code, input logic [5:0] fid,
                        input logic [7:0] value);
      lmfe_req_type item;
      item.op        = code;
      item.frame_id  = fid;
      item.data_byte = value;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   task automatic bus_byte(input logic [7:0] value);
      offer(OP_RX_BYTE, 6'($urandom_range(0, 63)), value);
   endtask

   task automatic ms_tick();
      offer(OP_TICK, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
   endtask

   task automatic header(input logic [5:0] fid);
      offer(OP_REQUEST, fid, 8'($urandom_range(0, 255)));
   endtask

   task automatic slave_answer(input logic [7:0] echo, input logic [7:0] value,
                               input logic [7:0] sum);
      bus_byte(echo);
      bus_byte(value);
      bus_byte(sum);
   endtask

   // Waits for every expected result, then for work that yields none to finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] ticks);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   task automatic maybe_tick();
      if ($urandom_range(0, 4) == 0)
         ms_tick();
   endtask

   // One random episode, mostly a request with a slave answer that is usually well-formed.
   task automatic random_episode();
      int         pick;
      int         n;
      logic [5:0] fid;
      logic [7:0] pid;
      logic [7:0] value;
      logic [7:0] echo;
      logic [7:0] sum;
      pick  = $urandom_range(0, 9);
      fid   = 6'($urandom_range(0, 63));
      value = 8'($urandom_range(0, 255));
      pid   = make_pid(fid);
      if (pick < 6) begin
         header(fid);
         echo = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : pid;
         sum  = enh_checksum(pid, value);
         if ($urandom_range(0, 5) == 0)
            sum = sum ^ 8'($urandom_range(1, 255));
         maybe_tick();
         bus_byte(echo);
         maybe_tick();
         bus_byte(value);
         maybe_tick();
         bus_byte(sum);
      end else if (pick < 8) begin
         offer(OP_COMMAND, fid, value);
      end else if (pick == 8) begin
         n = $urandom_range(1, 4);
         repeat (n) ms_tick();
      end else begin
         // A broken answer: a request followed by only part of the response.
         header(fid);
         n = $urandom_range(0, 2);
         repeat (n) bus_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic random_phase(input int count);
      int goal;
      goal = sent + count;
      while (sent < goal) random_episode();
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset timeout.
      header(6'h00);
      slave_answer(make_pid(6'h00), 8'h00, enh_checksum(make_pid(6'h00), 8'h00));
      header(6'h3F);
      slave_answer(make_pid(6'h3F), 8'hFF, enh_checksum(make_pid(6'h3F), 8'hFF));
      // Wrong echo and wrong checksum together: the echo is reported.
      header(6'h2A);
      slave_answer(8'h00, 8'h12, 8'h00);
      header(6'h15);
      slave_answer(make_pid(6'h15), 8'h80, ~enh_checksum(make_pid(6'h15), 8'h80));
      offer(OP_COMMAND, 6'h00, 8'h00);
      offer(OP_COMMAND, 6'h3F, 8'hFF);
      bus_byte(8'hA5);
      ms_tick();
      // A pending wait is dropped silently by a new request or a command.
      header(6'h01);
      bus_byte(make_pid(6'h01));
      header(6'h02);
      offer(OP_COMMAND, 6'h2B, 8'h5A);
      bus_byte(make_pid(6'h02));

      // Timeout settings at one, at zero, above the reset value and at the reset value.
      write_timeout(8'd1);
      header(6'h07);
      ms_tick();
      write_timeout(8'd0);
      header(6'h33);
      ms_tick();
      write_timeout(8'd12);
      header(6'h0C);
      repeat (12) ms_tick();
      write_timeout(8'd8);
      header(6'h11);
      bus_byte(make_pid(6'h11));
      repeat (8) ms_tick();

      // Hold the result side off while commands keep coming, so the block fills up.
      write_timeout(8'($urandom_range(3, 12)));
      hold_long = 1'b1;
      while (hold_long) @(negedge clock);
      repeat (12) offer(OP_COMMAND, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
      random_phase(14);

      write_timeout(8'd1);
      random_phase(12);
      write_timeout(8'd2);
      random_phase(12);
      write_timeout(8'($urandom_range(4, 20)));
      random_phase(12);

      calm = 1'b1;
      random_phase(14);
      settle();

      $display("Drove %0d transactions over %0d timeout settings.", txn_count, settings_used);
      $display("Checked %0d results, including %0d response verdicts and %0d timeouts.",
               result_count, verdict_count, timeout_count);
      if (error_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d expected results missing", error_count, outstanding);
         $display("FAIL");
      end
      $finish;
   end

endmodule
